>>> hdl/serial_two_wire_transaction_master_defines.svh
// Assertion macros shared by the two-wire master RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef SERIAL_TWO_WIRE_TRANSACTION_MASTER_DEFINES_SVH
`define SERIAL_TWO_WIRE_TRANSACTION_MASTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TSM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("two-wire master: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("two-wire master: next-cycle check failed");

`endif

>>> hdl/tsm_pkg.sv
// Shared types and constants of the two-wire transaction master.
// No dependencies; used by tsm_cfg_if and all modules by scoped names.
package tsm_pkg;

  localparam int TICK_COUNT_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH   = 16;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_UNIT_TICKS        = 3'd0,
    CFG_SETUP_UNITS       = 3'd1,
    CFG_HOLD_UNITS        = 3'd2,
    CFG_READ_UNITS        = 3'd3,
    CFG_TURNAROUND_UNITS  = 3'd4,
    CFG_EXPECTED_RESPONSE = 3'd5,
    CFG_ACK_LEVEL         = 3'd6
  } cfg_idx_t;

  // Request command codes
  localparam logic [1:0] CMD_TICK       = 2'd0;
  localparam logic [1:0] CMD_WRITE      = 2'd1;
  localparam logic [1:0] CMD_WRITE_READ = 2'd2;

  // Reset values of the configuration registers
  localparam logic [15:0] UNIT_TICKS_RST        = 16'd1000;
  localparam logic [7:0]  SETUP_UNITS_RST       = 8'd3;
  localparam logic [7:0]  HOLD_UNITS_RST        = 8'd5;
  localparam logic [7:0]  READ_UNITS_RST        = 8'd5;
  localparam logic [7:0]  TURNAROUND_UNITS_RST  = 8'd10;
  localparam logic [7:0]  EXPECTED_RESPONSE_RST = 8'h75;
  localparam logic        ACK_LEVEL_RST         = 1'b0;

  typedef struct packed {
    logic [15:0] unit_ticks;
    logic [7:0]  setup_units;
    logic [7:0]  hold_units;
    logic [7:0]  read_units;
    logic [7:0]  turnaround_units;
    logic [7:0]  expected_response;
    logic        ack_level;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       response_ok;
    logic       request_refused;
  } res_t;

endpackage

>>> hdl/tsm_req_if.sv
// Request channel: one tick word per transfer.
// Depends on nothing but its own signals.
interface tsm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic       sda_in;

  modport source (output valid, cmd, first_byte, second_byte, sda_in, input ready);
  modport sink   (input valid, cmd, first_byte, second_byte, sda_in, output ready);
endinterface

>>> hdl/tsm_res_if.sv
// Result channel: pin levels and status, one word per tick.
// Depends on nothing but its own signals.
interface tsm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       response_ok;
  logic       request_refused;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  read_byte, response_ok, request_refused, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  read_byte, response_ok, request_refused, output ready);
endinterface

>>> hdl/tsm_cfg_if.sv
// Configuration write channel: register index and write data.
// Widths from tsm_pkg.
interface tsm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tsm_pkg::CFG_INDEX_WIDTH-1:0] index;
  logic [tsm_pkg::CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/tsm_cfg.sv
// Configuration register file of the two-wire master.
// Depends on tsm_pkg and tsm_cfg_if.
module tsm_cfg (
  input  logic           clk,
  input  logic           rst,
  tsm_cfg_if.sink        cfg,
  output tsm_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.unit_ticks        <= tsm_pkg::UNIT_TICKS_RST;
      regs.setup_units       <= tsm_pkg::SETUP_UNITS_RST;
      regs.hold_units        <= tsm_pkg::HOLD_UNITS_RST;
      regs.read_units        <= tsm_pkg::READ_UNITS_RST;
      regs.turnaround_units  <= tsm_pkg::TURNAROUND_UNITS_RST;
      regs.expected_response <= tsm_pkg::EXPECTED_RESPONSE_RST;
      regs.ack_level         <= tsm_pkg::ACK_LEVEL_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        tsm_pkg::CFG_UNIT_TICKS:        regs.unit_ticks        <= cfg.data;
        tsm_pkg::CFG_SETUP_UNITS:       regs.setup_units       <= cfg.data[7:0];
        tsm_pkg::CFG_HOLD_UNITS:        regs.hold_units        <= cfg.data[7:0];
        tsm_pkg::CFG_READ_UNITS:        regs.read_units        <= cfg.data[7:0];
        tsm_pkg::CFG_TURNAROUND_UNITS:  regs.turnaround_units  <= cfg.data[7:0];
        tsm_pkg::CFG_EXPECTED_RESPONSE: regs.expected_response <= cfg.data[7:0];
        tsm_pkg::CFG_ACK_LEVEL:         regs.ack_level         <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/tsm_seq.sv
// Pin sequencer: phase, delay counters, shift registers and pin registers,
// advanced by one tick per accepted word. Depends on tsm_pkg.
module tsm_seq #(
  parameter int TICK_COUNT_WIDTH = tsm_pkg::TICK_COUNT_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  tsm_pkg::req_t req_word,
  input  tsm_pkg::cfg_t regs,
  output tsm_pkg::res_t res_next
);

  localparam int TW = TICK_COUNT_WIDTH;
  localparam int CW = (TW > 16) ? TW : 16;

  typedef enum logic [16:0] {
    PH_IDLE    = 17'd1 << 0,
    PH_S_DHI   = 17'd1 << 1,
    PH_S_CHI   = 17'd1 << 2,
    PH_S_DLO   = 17'd1 << 3,
    PH_S_CLO   = 17'd1 << 4,
    PH_T_BIT   = 17'd1 << 5,
    PH_T_CHI   = 17'd1 << 6,
    PH_T_CLO   = 17'd1 << 7,
    PH_T_TURN  = 17'd1 << 8,
    PH_R_HI    = 17'd1 << 9,
    PH_R_LO    = 17'd1 << 10,
    PH_A_LVL   = 17'd1 << 11,
    PH_A_PULSE = 17'd1 << 12,
    PH_P_CLO   = 17'd1 << 13,
    PH_P_DLO   = 17'd1 << 14,
    PH_P_CHI   = 17'd1 << 15,
    PH_P_DHI   = 17'd1 << 16
  } phase_t;

  // State registers
  phase_t        phase,          phase_next;
  logic [3:0]    bit_index,      bit_index_next;
  logic [TW-1:0] tick_count,     tick_count_next;
  logic [7:0]    unit_count,     unit_count_next;
  logic [7:0]    shift_out,      shift_out_next;
  logic [7:0]    pending_second, pending_second_next;
  logic [7:0]    shift_in,       shift_in_next;
  logic          read_wanted,    read_wanted_next;
  logic          scl,            scl_next;
  logic          sda_lvl,        sda_lvl_next;
  logic          sda_drv,        sda_drv_next;
  logic [7:0]    last_read,      last_read_next;
  logic          resp_ok,        resp_ok_next;

  // Step working signals
  logic          request;
  logic [7:0]    span;
  logic [15:0]   unit_len;
  logic [TW-1:0] tick_inc;
  logic          unit_end;
  logic [7:0]    unit_inc;
  logic          span_over;
  logic          do_enter;
  phase_t        target;
  logic          refused;
  logic          done;

  assign request = (req_word.cmd == tsm_pkg::CMD_WRITE) ||
                   (req_word.cmd == tsm_pkg::CMD_WRITE_READ);

  // Span length of the current step, in delay units
  always_comb begin
    case (phase)
      PH_S_DHI, PH_S_DLO, PH_T_BIT, PH_T_CLO, PH_P_CLO, PH_P_CHI:
        span = regs.setup_units;
      PH_S_CHI, PH_S_CLO, PH_T_CHI, PH_P_DLO, PH_P_DHI:
        span = regs.hold_units;
      PH_T_TURN:
        span = regs.turnaround_units;
      PH_R_HI, PH_R_LO, PH_A_LVL:
        span = regs.read_units;
      default:
        span = 8'd0;
    endcase
  end

  // Delay counting: a unit ends at unit_ticks or when the counter saturates
  assign unit_len = (regs.unit_ticks == 16'd0) ? 16'd1 : regs.unit_ticks;
  assign tick_inc = tick_count + {{(TW-1){1'b0}}, 1'b1};
  assign unit_end = (CW'(tick_inc) >= CW'(unit_len)) || (&tick_inc);
  assign unit_inc = unit_count + 8'd1;

  always_comb begin
    phase_next          = phase;
    bit_index_next      = bit_index;
    tick_count_next     = tick_count;
    unit_count_next     = unit_count;
    shift_out_next      = shift_out;
    pending_second_next = pending_second;
    shift_in_next       = shift_in;
    read_wanted_next    = read_wanted;
    scl_next            = scl;
    sda_lvl_next        = sda_lvl;
    sda_drv_next        = sda_drv;
    last_read_next      = last_read;
    resp_ok_next        = resp_ok;
    refused             = 1'b0;
    done                = 1'b0;
    do_enter            = 1'b0;
    target              = PH_IDLE;
    span_over           = 1'b0;

    if (phase == PH_IDLE) begin
      // Start of a transaction
      if (request) begin
        shift_out_next      = req_word.first_byte;
        pending_second_next = req_word.second_byte;
        read_wanted_next    = (req_word.cmd == tsm_pkg::CMD_WRITE_READ);
        bit_index_next      = 4'd0;
        do_enter            = 1'b1;
        target              = PH_S_DHI;
      end
    end else begin
      refused = request;
      // Step timing
      if (span == 8'd0) begin
        span_over = 1'b1;
      end else if (unit_end) begin
        unit_count_next = unit_inc;
        if (unit_inc >= span) begin
          span_over = 1'b1;
        end else begin
          tick_count_next = '0;
        end
      end else begin
        tick_count_next = tick_inc;
      end

      // Phase transitions
      if (span_over) begin
        do_enter = 1'b1;
        case (phase)
          PH_S_DHI: target = PH_S_CHI;
          PH_S_CHI: target = PH_S_DLO;
          PH_S_DLO: target = PH_S_CLO;
          PH_S_CLO: begin
            bit_index_next = 4'd7;
            target         = PH_T_BIT;
          end
          PH_T_BIT: target = PH_T_CHI;
          PH_T_CHI: target = (bit_index[2:0] != 3'd0) ? PH_T_CLO : PH_T_TURN;
          PH_T_CLO: begin
            bit_index_next = {bit_index[3], bit_index[2:0] - 3'd1};
            target         = PH_T_BIT;
          end
          PH_T_TURN: begin
            if (!bit_index[3]) begin
              shift_out_next = pending_second;
              bit_index_next = 4'd15;
              target         = PH_T_BIT;
            end else if (read_wanted) begin
              bit_index_next = 4'd0;
              shift_in_next  = 8'd0;
              target         = PH_R_HI;
            end else begin
              target = PH_P_CLO;
            end
          end
          PH_R_HI: begin
            shift_in_next = {shift_in[6:0], req_word.sda_in};
            target        = PH_R_LO;
          end
          PH_R_LO: begin
            bit_index_next = bit_index + 4'd1;
            target         = bit_index_next[3] ? PH_A_LVL : PH_R_HI;
          end
          PH_A_LVL: begin
            last_read_next = shift_in;
            resp_ok_next   = (shift_in == regs.expected_response);
            target         = PH_A_PULSE;
          end
          PH_A_PULSE: target = PH_P_CLO;
          PH_P_CLO:   target = PH_P_DLO;
          PH_P_DLO:   target = PH_P_CHI;
          PH_P_CHI:   target = PH_P_DHI;
          PH_P_DHI: begin
            do_enter   = 1'b0;
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
          default: begin
            do_enter   = 1'b0;
            phase_next = PH_IDLE;
          end
        endcase
      end
    end

    // Entry actions of the new step
    if (do_enter) begin
      phase_next      = target;
      tick_count_next = '0;
      unit_count_next = 8'd0;
      case (target)
        PH_S_DHI: begin
          sda_drv_next = 1'b1;
          sda_lvl_next = 1'b1;
        end
        PH_S_CHI: scl_next = 1'b1;
        PH_S_DLO: sda_lvl_next = 1'b0;
        PH_S_CLO: scl_next = 1'b0;
        PH_T_BIT: begin
          sda_drv_next = 1'b1;
          sda_lvl_next = shift_out_next[bit_index_next[2:0]];
        end
        PH_T_CHI: scl_next = 1'b1;
        PH_T_CLO: scl_next = 1'b0;
        PH_T_TURN: begin
          scl_next = 1'b0;
          if (bit_index_next[3]) sda_drv_next = 1'b0;
        end
        PH_R_HI: begin
          scl_next     = 1'b1;
          sda_drv_next = 1'b0;
        end
        PH_R_LO: scl_next = 1'b0;
        PH_A_LVL: begin
          sda_drv_next = 1'b1;
          sda_lvl_next = regs.ack_level;
        end
        PH_A_PULSE: scl_next = 1'b1;
        PH_P_CLO: begin
          scl_next     = 1'b0;
          sda_drv_next = 1'b1;
        end
        PH_P_DLO: sda_lvl_next = 1'b0;
        PH_P_CHI: scl_next = 1'b1;
        PH_P_DHI: sda_lvl_next = 1'b1;
        default:  phase_next = PH_IDLE;
      endcase
    end
  end

  // Result word shows the state after this tick
  always_comb begin
    res_next.scl_level       = scl_next;
    res_next.sda_level       = sda_lvl_next;
    res_next.sda_drive       = sda_drv_next;
    res_next.busy_res        = (phase_next != PH_IDLE);
    res_next.done_res        = done;
    res_next.read_byte       = last_read_next;
    res_next.response_ok     = resp_ok_next;
    res_next.request_refused = refused;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_index      <= 4'd0;
      tick_count     <= '0;
      unit_count     <= 8'd0;
      shift_out      <= 8'd0;
      pending_second <= 8'd0;
      shift_in       <= 8'd0;
      read_wanted    <= 1'b0;
      scl            <= 1'b1;
      sda_lvl        <= 1'b1;
      sda_drv        <= 1'b0;
      last_read      <= 8'd0;
      resp_ok        <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      bit_index      <= bit_index_next;
      tick_count     <= tick_count_next;
      unit_count     <= unit_count_next;
      shift_out      <= shift_out_next;
      pending_second <= pending_second_next;
      shift_in       <= shift_in_next;
      read_wanted    <= read_wanted_next;
      scl            <= scl_next;
      sda_lvl        <= sda_lvl_next;
      sda_drv        <= sda_drv_next;
      last_read      <= last_read_next;
      resp_ok        <= resp_ok_next;
    end
  end

endmodule

>>> hdl/tsm_out_reg.sv
// Result register: holds one result word until the sink takes it.
// Depends on tsm_pkg and tsm_res_if.
module tsm_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  tsm_pkg::res_t res_next,
  output logic          room,
  tsm_res_if.source     res
);

  tsm_pkg::res_t word;
  logic          full;

  // Space for a new word when empty or when the held word leaves now
  assign room = !full || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (res.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) word <= res_next;
  end

  assign res.valid           = full;
  assign res.scl_level       = word.scl_level;
  assign res.sda_level       = word.sda_level;
  assign res.sda_drive       = word.sda_drive;
  assign res.busy_res        = word.busy_res;
  assign res.done_res        = word.done_res;
  assign res.read_byte       = word.read_byte;
  assign res.response_ok     = word.response_ok;
  assign res.request_refused = word.request_refused;

endmodule

>>> hdl/serial_two_wire_transaction_master.sv
// Top level of the two-wire transaction master.
// Depends on tsm_pkg, the channel interfaces, tsm_cfg, tsm_seq, tsm_out_reg.
//
// Usage:
//   req  - one word per clock tick of the pin sequencer: cmd (tick only, write
//          pair, write pair then read), the two bytes to send and the sampled
//          data line level. A start command is taken only while idle.
//   res  - one word per request word: clock and data pin levels, data drive
//          enable, busy, done pulse, last read byte, response match flag and a
//          flag for a start request refused while busy.
//   cfg  - register writes (index, data); always ready. Write only while idle.
// Latency: a result word is valid the cycle after its request word is taken.
// Throughput: one word per cycle while the result register has room; the
//   sequencer next-state logic is combinational from state to result register.
// Stall: while the result register is full and not taken, req.ready is low and
//   the sequencer holds; a word taken on the same edge lets a new one in.
// Reset: clock line high, data line released at level 1, phase idle, read byte
//   and match flag zero, configuration registers at their default values.
`include "serial_two_wire_transaction_master_defines.svh"

module serial_two_wire_transaction_master #(
  parameter int TICK_COUNT_WIDTH = tsm_pkg::TICK_COUNT_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  tsm_req_if.sink    req,
  tsm_res_if.source  res,
  tsm_cfg_if.sink    cfg
);

  tsm_pkg::cfg_t regs;
  tsm_pkg::req_t req_word;
  tsm_pkg::res_t res_next;
  logic          room;
  logic          step;

  assign req.ready = room;
  assign step      = req.valid && req.ready;

  assign req_word.cmd         = req.cmd;
  assign req_word.first_byte  = req.first_byte;
  assign req_word.second_byte = req.second_byte;
  assign req_word.sda_in      = req.sda_in;

  tsm_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  tsm_seq #(
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .req_word (req_word),
    .regs     (regs),
    .res_next (res_next)
  );

  tsm_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .res_next (res_next),
    .room     (room),
    .res      (res)
  );

  // Checks
  `TSM_ASSERT_NOW(a_no_overwrite, clk, rst, step && res.valid, res.ready)
  `TSM_ASSERT_NOW(a_done_not_busy, clk, rst, res.valid && res.done_res, !res.busy_res)
  `TSM_ASSERT_NEXT(a_word_follows, clk, rst, step, res.valid)
  `TSM_ASSERT_NEXT(a_held_when_stalled, clk, rst, res.valid && !res.ready && !step,
                   res.valid)

endmodule
